[sv/rgb_to_rgbw_via_hsi_top_defines.svh]
// Assertion macros used by the RGBW converter top level.
`ifndef RGB_TO_RGBW_VIA_HSI_TOP_DEFINES_SVH
`define RGB_TO_RGBW_VIA_HSI_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, idle during reset.
`define RGBW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk, idle during reset.
`define RGBW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rgbw_pkg.sv]
// ----------------------------------------------------------------------------
// rgbw_pkg
// Shared types, constants and helper functions for the RGB to RGBW converter.
// ----------------------------------------------------------------------------
package rgbw_pkg;

    localparam int unsigned RATIO_TABLE_SIZE_DEF = 256;

    // Long division: 20 quotient bits, 4 per pipeline stage
    localparam int unsigned DIV_QW     = 20;
    localparam int unsigned DIV_STEP   = 4;
    localparam int unsigned DIV_STAGES = DIV_QW / DIV_STEP;
    localparam int unsigned NUM_W      = 26;
    localparam int unsigned DEN_W      = 10;

    localparam logic [15:0] SECTOR_Q7 = 16'd15360;
    localparam logic [15:0] FULL_Q7   = 16'd46080;

    // floor(sum * 65536 / 765) == (sum * IQ_RECIP) >> 20 for sum <= 765
    localparam logic [26:0] IQ_RECIP  = 27'd89829382;
    // floor(y / 15) == (y * DIV15_RECIP) >> 20 for y < 2^16
    localparam logic [16:0] DIV15_RECIP = 17'd69906;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    typedef enum logic [1:0] {MAX_RED, MAX_GREEN, MAX_BLUE} max_sel_t;
    typedef enum logic [1:0] {SEC_RG, SEC_GB, SEC_BR} sector_t;

    typedef struct packed {
        logic [7:0]  led_index;
        max_sel_t    max_sel;
        logic [16:0] iq;
    } div_side_t;

    typedef struct packed {
        div_side_t        side;
        logic [NUM_W-1:0] sat_num;
        logic [DEN_W-1:0] sat_den;
        logic [NUM_W-1:0] hue_num;
        logic [DEN_W-1:0] hue_den;
    } div_in_t;

    typedef struct packed {
        div_side_t         side;
        logic [DIV_QW-1:0] sat_quo;
        logic [DIV_QW-1:0] hue_quo;
    } div_out_t;

    // Four restoring-division steps; rem stays below den
    function automatic logic [DEN_W+DIV_STEP-1:0] div_step4(
        input logic [DEN_W-1:0]    rem,
        input logic [DIV_STEP-1:0] bits,
        input logic [DEN_W-1:0]    den
    );
        logic [DEN_W:0]      t;
        logic [DEN_W-1:0]    r;
        logic [DIV_STEP-1:0] q;
        r = rem;
        q = '0;
        for (int i = DIV_STEP - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, den})
            begin
                t    = t - {1'b0, den};
                q[i] = 1'b1;
            end
            r = t[DEN_W-1:0];
        end
        return {r, q};
    endfunction

    // Shift-subtract unsigned division, elaboration use only
    function automatic longint unsigned udiv64(
        input longint unsigned num,
        input longint unsigned den
    );
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor cosine, Q30 in and out, elaboration use only
    function automatic longint cos_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        acc  = longint'(ONE_Q30);
        for (int k = 1; k <= 9; k++)
        begin
            term = udiv64((term * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return acc;
    endfunction

    // cos(a)/cos(60-a) in signed Q2.14, a = idx*120/n degrees
    function automatic logic signed [16:0] ratio_entry(
        input int unsigned idx,
        input int unsigned n
    );
        longint unsigned xh;
        longint unsigned dd;
        longint unsigned xd;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        longint          ch;
        longint          cd;
        xh  = udiv64(longint'(idx) * 2 * PI_Q30, 3 * longint'(n));
        dd  = (2 * idx > n) ? longint'(2 * idx - n) : longint'(n - 2 * idx);
        xd  = udiv64(dd * PI_Q30, 3 * longint'(n));
        ch  = cos_q30(xh);
        cd  = cos_q30(xd);
        mag = (ch < 0) ? longint'(-ch) : longint'(ch);
        den = (cd > 0) ? longint'(cd) : 64'd1;
        q   = udiv64(mag * 32768 + den, 2 * den);
        return (ch < 0) ? -17'(q) : 17'(q);
    endfunction

endpackage

[sv/rgb_to_rgbw_via_hsi_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_rgbw_via_hsi_top
// RGB pixel to RGBW LED drive bytes through hue, saturation and intensity.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries led_index and in_red/in_green/
//   in_blue; a transaction happens when both are high on a clock edge.
//   Output channel out_valid/out_ready returns out_index, out_red, out_green,
//   out_blue and out_white, one result per input, in input order.
//   The pipe is two front stages (sum, extremes, operands), five
//   divider stages of four quotient bits each, and seven scaling stages, the
//   last of which is the output register.
//   Throughput is one pixel per cycle while in_ready is high; each stage
//   holds its own valid bit. When the receiver stalls, the output register
//   holds its transaction and stages behind it keep filling until every
//   stage is occupied; only then does in_ready drop. Nothing is lost or
//   repeated. Reset (rst_n low, asynchronous) empties every stage; the ratio
//   table is constant logic and needs no fill time.
// ----------------------------------------------------------------------------
`include "rgb_to_rgbw_via_hsi_top_defines.svh"

module rgb_to_rgbw_via_hsi_top
    import rgbw_pkg::*;
#(
    parameter int unsigned RATIO_TABLE_SIZE = RATIO_TABLE_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] led_index,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_index,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_white
);

    logic     fd_valid, fd_ready;
    div_in_t  fd_data;
    logic     db_valid, db_ready;
    div_out_t db_data;

    rgbw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .led_index (led_index),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .dn_valid  (fd_valid),
        .dn_ready  (fd_ready),
        .dn_data   (fd_data)
    );

    rgbw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (fd_valid),
        .up_ready (fd_ready),
        .up_data  (fd_data),
        .dn_valid (db_valid),
        .dn_ready (db_ready),
        .dn_data  (db_data)
    );

    rgbw_back #(
        .RATIO_TABLE_SIZE (RATIO_TABLE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (db_valid),
        .up_ready  (db_ready),
        .up_data   (db_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_index (out_index),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_white (out_white)
    );

    // input backs up only when the whole pipe is full and the sink stalls
    `RGBW_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid && !out_ready, "in_ready low while pipeline not blocked")
    // one primary is always left dark
    `RGBW_ASSERT_NOW(a_one_primary_zero, out_valid, out_red == 8'd0 || out_green == 8'd0 || out_blue == 8'd0, "all three primaries lit")
    `RGBW_ASSERT_NOW(a_white_range, out_valid, out_white <= 8'd85, "white above 85")
    `RGBW_ASSERT_NOW(a_div_range, db_valid, db_data.sat_quo <= 20'd65536 && db_data.hue_quo <= 20'd53760, "divider quotient out of range")

endmodule

[sv/rgbw_front.sv]
// ----------------------------------------------------------------------------
// rgbw_front
// Two stages: channel sum and extremes, then intensity and divider operands.
// ----------------------------------------------------------------------------
module rgbw_front
    import rgbw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] led_index,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    output logic       dn_valid,
    input  logic       dn_ready,
    output div_in_t    dn_data
);

    logic [1:0] v_reg;
    logic [1:0] ld;

    logic [7:0] idx1_reg, r1_reg, g1_reg, b1_reg, mx1_reg, mn1_reg;
    logic [9:0] sum1_reg;
    max_sel_t   sel1_reg;

    logic [7:0] mx_next, mn_next;
    logic [9:0] sum_next;
    max_sel_t   sel_next;

    div_in_t    d2_reg;
    div_in_t    d2_next;

    logic [7:0]  c;
    logic [11:0] nh;
    logic [9:0]  sn;
    logic [36:0] iq_prod;
    logic [23:0] hue_prod;

    assign ld[1]    = !v_reg[1] || dn_ready;
    assign ld[0]    = !v_reg[0] || ld[1];
    assign in_ready = ld[0];
    assign dn_valid = v_reg[1];
    assign dn_data  = d2_reg;

    always_comb
    begin
        mx_next = in_red;
        mn_next = in_red;
        if (in_green > mx_next) mx_next = in_green;
        if (in_blue > mx_next)  mx_next = in_blue;
        if (in_green < mn_next) mn_next = in_green;
        if (in_blue < mn_next)  mn_next = in_blue;
        sum_next = {2'b0, in_red} + {2'b0, in_green} + {2'b0, in_blue};
        // blue beats green, green beats red on a tie
        if (in_blue == mx_next)
            sel_next = MAX_BLUE;
        else if (in_green == mx_next)
            sel_next = MAX_GREEN;
        else
            sel_next = MAX_RED;
    end

    always_comb
    begin
        c = mx1_reg - mn1_reg;
        case (sel1_reg)
            MAX_BLUE:  nh = {2'b0, c, 2'b0} + {4'b0, r1_reg} - {4'b0, g1_reg};
            MAX_GREEN: nh = {3'b0, c, 1'b0} + {4'b0, b1_reg} - {4'b0, r1_reg};
            default:   nh = {2'b0, c, 2'b0} + {3'b0, c, 1'b0}
                            + {4'b0, g1_reg} - {4'b0, b1_reg};
        endcase
        sn       = sum1_reg - ({2'b0, mn1_reg} + {1'b0, mn1_reg, 1'b0});
        iq_prod  = {27'b0, sum1_reg} * {10'b0, IQ_RECIP};
        hue_prod = {12'b0, nh} * 24'd7680;

        d2_next.side.led_index = idx1_reg;
        d2_next.side.max_sel   = sel1_reg;
        d2_next.side.iq        = iq_prod[36:20];
        if (c == 8'd0)
        begin
            // grey: hue and saturation come out as zero
            d2_next.sat_num = '0;
            d2_next.sat_den = DEN_W'(1);
            d2_next.hue_num = '0;
            d2_next.hue_den = DEN_W'(1);
        end
        else
        begin
            d2_next.sat_num = {sn, 16'b0};
            d2_next.sat_den = sum1_reg;
            d2_next.hue_num = {2'b0, hue_prod};
            d2_next.hue_den = {2'b0, c};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ld[0]) v_reg[0] <= in_valid;
            if (ld[1]) v_reg[1] <= v_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            idx1_reg <= led_index;
            r1_reg   <= in_red;
            g1_reg   <= in_green;
            b1_reg   <= in_blue;
            mx1_reg  <= mx_next;
            mn1_reg  <= mn_next;
            sum1_reg <= sum_next;
            sel1_reg <= sel_next;
        end
        if (ld[1])
            d2_reg <= d2_next;
    end

endmodule

[sv/rgbw_div.sv]
// ----------------------------------------------------------------------------
// rgbw_div
// Pipelined restoring divider pair for saturation and hue, four bits a stage.
// ----------------------------------------------------------------------------
module rgbw_div
    import rgbw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  div_in_t  up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output div_out_t dn_data
);

    logic [DIV_STAGES-1:0] v_reg;
    logic [DIV_STAGES-1:0] ld;

    div_side_t         side_reg [DIV_STAGES];
    logic [DEN_W-1:0]  srem_reg [DIV_STAGES];
    logic [DEN_W-1:0]  hrem_reg [DIV_STAGES];
    logic [DEN_W-1:0]  sden_reg [DIV_STAGES];
    logic [DEN_W-1:0]  hden_reg [DIV_STAGES];
    logic [DIV_QW-1:0] slow_reg [DIV_STAGES];
    logic [DIV_QW-1:0] hlow_reg [DIV_STAGES];
    logic [DIV_QW-1:0] squo_reg [DIV_STAGES];
    logic [DIV_QW-1:0] hquo_reg [DIV_STAGES];

    assign up_ready = ld[0];
    assign dn_valid = v_reg[DIV_STAGES-1];
    assign dn_data  = '{side:    side_reg[DIV_STAGES-1],
                        sat_quo: squo_reg[DIV_STAGES-1],
                        hue_quo: hquo_reg[DIV_STAGES-1]};

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int unsigned HI = DIV_QW - 1 - s * DIV_STEP;

        logic              v_in;
        div_side_t         side_in;
        logic [DEN_W-1:0]  srem_in, hrem_in, sden_in, hden_in;
        logic [DIV_QW-1:0] slow_in, hlow_in, squo_in, hquo_in;
        logic [DEN_W+DIV_STEP-1:0] sres_next, hres_next;
        logic [DIV_QW-1:0] squo_next, hquo_next;

        if (s == 0)
        begin : g_first
            assign ld[s]   = !v_reg[s] || ld[s+1];
            assign v_in    = up_valid;
            assign side_in = up_data.side;
            assign srem_in = DEN_W'(up_data.sat_num[NUM_W-1:DIV_QW]);
            assign hrem_in = DEN_W'(up_data.hue_num[NUM_W-1:DIV_QW]);
            assign sden_in = up_data.sat_den;
            assign hden_in = up_data.hue_den;
            assign slow_in = up_data.sat_num[DIV_QW-1:0];
            assign hlow_in = up_data.hue_num[DIV_QW-1:0];
            assign squo_in = '0;
            assign hquo_in = '0;
        end
        else
        begin : g_next
            if (s == DIV_STAGES - 1)
            begin : g_last
                assign ld[s] = !v_reg[s] || dn_ready;
            end
            else
            begin : g_mid
                assign ld[s] = !v_reg[s] || ld[s+1];
            end
            assign v_in    = v_reg[s-1];
            assign side_in = side_reg[s-1];
            assign srem_in = srem_reg[s-1];
            assign hrem_in = hrem_reg[s-1];
            assign sden_in = sden_reg[s-1];
            assign hden_in = hden_reg[s-1];
            assign slow_in = slow_reg[s-1];
            assign hlow_in = hlow_reg[s-1];
            assign squo_in = squo_reg[s-1];
            assign hquo_in = hquo_reg[s-1];
        end

        always_comb
        begin
            sres_next = div_step4(srem_in, slow_in[HI -: DIV_STEP], sden_in);
            hres_next = div_step4(hrem_in, hlow_in[HI -: DIV_STEP], hden_in);
            squo_next = squo_in;
            hquo_next = hquo_in;
            squo_next[HI -: DIV_STEP] = sres_next[DIV_STEP-1:0];
            hquo_next[HI -: DIV_STEP] = hres_next[DIV_STEP-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (ld[s])
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (ld[s])
            begin
                side_reg[s] <= side_in;
                srem_reg[s] <= sres_next[DEN_W+DIV_STEP-1:DIV_STEP];
                hrem_reg[s] <= hres_next[DEN_W+DIV_STEP-1:DIV_STEP];
                sden_reg[s] <= sden_in;
                hden_reg[s] <= hden_in;
                slow_reg[s] <= slow_in;
                hlow_reg[s] <= hlow_in;
                squo_reg[s] <= squo_next;
                hquo_reg[s] <= hquo_next;
            end
        end
    end

endmodule

[sv/rgbw_back.sv]
// ----------------------------------------------------------------------------
// rgbw_back
// Sector split, ratio lookup and primary/white scaling; last stage is the
// output register.
// ----------------------------------------------------------------------------
module rgbw_back
    import rgbw_pkg::*;
#(
    parameter int unsigned RATIO_TABLE_SIZE = RATIO_TABLE_SIZE_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  div_out_t   up_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_index,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_white
);

    localparam int unsigned NST   = 7;
    localparam int unsigned IDX_W = $clog2(RATIO_TABLE_SIZE);
    localparam int unsigned HS_W  = 14 + $clog2(RATIO_TABLE_SIZE + 1);
    localparam int unsigned Y_W   = HS_W - 10;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] ld;

    logic signed [16:0] rom_vec [RATIO_TABLE_SIZE];

    for (genvar gi = 0; gi < RATIO_TABLE_SIZE; gi++)
    begin : g_rom
        localparam logic signed [16:0] ENTRY = ratio_entry(gi, RATIO_TABLE_SIZE);
        assign rom_vec[gi] = ENTRY;
    end

    // ready chain, bubbles collapse
    for (genvar k = 0; k < NST; k++)
    begin : g_ld
        if (k == NST - 1)
        begin : g_last
            assign ld[k] = !v_reg[k] || out_ready;
        end
        else
        begin : g_mid
            assign ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign up_ready  = ld[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (ld[0])
                v_reg[0] <= up_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (ld[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1: hue wrap, sector, S*I and (1-S)*I
    logic [7:0]  idx1_reg;
    sector_t     sec1_reg;
    logic [13:0] h1_reg;
    logic [32:0] si1_reg, wa1_reg;
    logic [15:0] hq;
    sector_t     sec_next;
    logic [15:0] h_next;
    logic [33:0] si_prod, wa_prod;
    logic [16:0] sq, nsq;

    always_comb
    begin
        hq = up_data.hue_quo[15:0];
        if (up_data.side.max_sel == MAX_RED && hq >= FULL_Q7)
            hq = hq - FULL_Q7;
        if (hq < SECTOR_Q7)
        begin
            sec_next = SEC_RG;
            h_next   = hq;
        end
        else if (hq < {SECTOR_Q7[14:0], 1'b0})
        begin
            sec_next = SEC_GB;
            h_next   = hq - SECTOR_Q7;
        end
        else
        begin
            sec_next = SEC_BR;
            h_next   = hq - {SECTOR_Q7[14:0], 1'b0};
        end
        sq      = up_data.sat_quo[16:0];
        nsq     = 17'h10000 - sq;
        si_prod = {17'b0, sq} * {17'b0, up_data.side.iq};
        wa_prod = {17'b0, nsq} * {17'b0, up_data.side.iq};
    end

    // stage 2: table position product, white
    logic [7:0]      idx2_reg, w2_reg;
    sector_t         sec2_reg;
    logic [HS_W-1:0] hs2_reg;
    logic [32:0]     si2_reg;
    logic [HS_W-1:0] hs_next;
    logic [39:0]     w_prod;
    logic [7:0]      w_next;

    always_comb
    begin
        hs_next = HS_W'(h1_reg) * HS_W'(RATIO_TABLE_SIZE);
        w_prod  = {7'b0, wa1_reg} * 40'd85;
        w_next  = (w_prod[39:32] > 8'd255) ? 8'd255 : w_prod[39:32];
    end

    // stage 3: table index = floor(h * size / 15360)
    logic [7:0]       idx3_reg, w3_reg;
    sector_t          sec3_reg;
    logic [IDX_W-1:0] ti3_reg;
    logic [32:0]      si3_reg;
    logic [Y_W+16:0]  ti_prod;
    logic [Y_W-4:0]   ti_q;
    logic [IDX_W-1:0] ti_next;

    always_comb
    begin
        ti_prod = {17'b0, hs2_reg[HS_W-1:10]} * {Y_W'(0), DIV15_RECIP};
        ti_q    = ti_prod[Y_W+16:20];
        if (ti_q >= (Y_W-3)'(RATIO_TABLE_SIZE))
            ti_next = IDX_W'(RATIO_TABLE_SIZE - 1);
        else
            ti_next = ti_q[IDX_W-1:0];
    end

    // stage 4: ratio lookup and primary factors
    logic [7:0]  idx4_reg, w4_reg;
    sector_t     sec4_reg;
    logic [32:0] si4_reg;
    logic [15:0] f1_4_reg, f2_4_reg;
    logic signed [17:0] ratio, fs1, fs2;
    logic [15:0] f1_next, f2_next;

    always_comb
    begin
        ratio   = 18'(rom_vec[ti3_reg]);
        fs1     = 18'sd16384 + ratio;
        fs2     = 18'sd32768 - ratio;
        f1_next = (fs1 > 18'sd0) ? fs1[15:0] : 16'd0;
        f2_next = (fs2 > 18'sd0) ? fs2[15:0] : 16'd0;
    end

    // stage 5: 85 times factor
    logic [7:0]  idx5_reg, w5_reg;
    sector_t     sec5_reg;
    logic [32:0] si5_reg;
    logic [22:0] g1_5_reg, g2_5_reg;

    // stage 6: partial products of S*I*85*factor
    logic [7:0]  idx6_reg, w6_reg;
    sector_t     sec6_reg;
    logic [39:0] ph1_reg, ph2_reg;
    logic [38:0] pl1_reg, pl2_reg;

    // stage 7: combine, scale, saturate, map into colors
    logic [7:0] idx7_reg, w7_reg, r7_reg, g7_reg, b7_reg;
    logic [55:0] p1_full, p2_full;
    logic [7:0]  p1, p2;
    logic [7:0]  r_next, g_next, b_next;

    always_comb
    begin
        p1_full = {ph1_reg, 16'b0} + {17'b0, pl1_reg};
        p2_full = {ph2_reg, 16'b0} + {17'b0, pl2_reg};
        p1      = (p1_full[55:46] > 10'd255) ? 8'd255 : p1_full[53:46];
        p2      = (p2_full[55:46] > 10'd255) ? 8'd255 : p2_full[53:46];
        case (sec6_reg)
            SEC_RG:
            begin
                r_next = p1;
                g_next = p2;
                b_next = 8'd0;
            end
            SEC_GB:
            begin
                r_next = 8'd0;
                g_next = p1;
                b_next = p2;
            end
            default:
            begin
                r_next = p2;
                g_next = 8'd0;
                b_next = p1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            idx1_reg <= up_data.side.led_index;
            sec1_reg <= sec_next;
            h1_reg   <= h_next[13:0];
            si1_reg  <= si_prod[32:0];
            wa1_reg  <= wa_prod[32:0];
        end
        if (ld[1])
        begin
            idx2_reg <= idx1_reg;
            sec2_reg <= sec1_reg;
            hs2_reg  <= hs_next;
            si2_reg  <= si1_reg;
            w2_reg   <= w_next;
        end
        if (ld[2])
        begin
            idx3_reg <= idx2_reg;
            sec3_reg <= sec2_reg;
            ti3_reg  <= ti_next;
            si3_reg  <= si2_reg;
            w3_reg   <= w2_reg;
        end
        if (ld[3])
        begin
            idx4_reg <= idx3_reg;
            sec4_reg <= sec3_reg;
            si4_reg  <= si3_reg;
            w4_reg   <= w3_reg;
            f1_4_reg <= f1_next;
            f2_4_reg <= f2_next;
        end
        if (ld[4])
        begin
            idx5_reg <= idx4_reg;
            sec5_reg <= sec4_reg;
            si5_reg  <= si4_reg;
            w5_reg   <= w4_reg;
            g1_5_reg <= {7'b0, f1_4_reg} * 23'd85;
            g2_5_reg <= {7'b0, f2_4_reg} * 23'd85;
        end
        if (ld[5])
        begin
            idx6_reg <= idx5_reg;
            sec6_reg <= sec5_reg;
            w6_reg   <= w5_reg;
            ph1_reg  <= {23'b0, si5_reg[32:16]} * {17'b0, g1_5_reg};
            ph2_reg  <= {23'b0, si5_reg[32:16]} * {17'b0, g2_5_reg};
            pl1_reg  <= {23'b0, si5_reg[15:0]} * {16'b0, g1_5_reg};
            pl2_reg  <= {23'b0, si5_reg[15:0]} * {16'b0, g2_5_reg};
        end
        if (ld[6])
        begin
            idx7_reg <= idx6_reg;
            w7_reg   <= w6_reg;
            r7_reg   <= r_next;
            g7_reg   <= g_next;
            b7_reg   <= b_next;
        end
    end

    assign out_index = idx7_reg;
    assign out_red   = r7_reg;
    assign out_green = g7_reg;
    assign out_blue  = b7_reg;
    assign out_white = w7_reg;

endmodule
